[src/bvs_pkg.sv]
// shared types and constants for the bounded value set
package bvs_pkg;

   localparam int CAPACITY_MAX_DEFAULT = 128;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 8;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_QUERY  = 2'd2,
      KIND_SPARE  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [1:0]                kind;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic               was_present;
      logic               full_reject;
      logic [COUNT_W-1:0] count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_MOVE,
      ST_DONE
   } state_type;

endpackage

[src/bounded_value_set_top.sv]
// bounded value set: insert, remove and membership query over a packed table
//
// Holds up to CAPACITY_MAX distinct 32-bit values in a single-port-read
// synchronous table with a live count. One transaction is processed at a
// time: the table is scanned linearly, one entry read per cycle through a
// registered read port, stopping at the first match. A remove that finds
// its value also reads the last entry and writes it into the freed slot.
// The scan through the table read port sets how long a transaction takes.
// The result is held in an output register, so a new request is taken
// while a result still waits. count reports the low 8 bits of the number
// of elements held.
module bounded_value_set_top #(
   parameter int CAPACITY_MAX = bvs_pkg::CAPACITY_MAX_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bvs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bvs_pkg::rsp_type rsp_data
);
   import bvs_pkg::*;

   localparam int ADDR_W = (CAPACITY_MAX > 1) ? $clog2(CAPACITY_MAX) : 1;
   localparam int CNT_W  = $clog2(CAPACITY_MAX + 1);

   logic [VALUE_W-1:0] mem [CAPACITY_MAX];

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               pend_ff, pend_in;
   logic [ADDR_W-1:0]  rd_idx_ff, rd_idx_in;
   logic               hit_ff, hit_in;
   logic [ADDR_W-1:0]  slot_ff, slot_in;
   logic               reject_ff, reject_in;
   logic [VALUE_W-1:0] rd_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               mem_we;
   logic [ADDR_W-1:0]  mem_wa;
   logic [VALUE_W-1:0] mem_wd;
   logic [ADDR_W-1:0]  mem_ra;
   logic               hit_now;
   logic [CNT_W-1:0]   last;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      idx_ff    <= idx_in;
      rd_idx_ff <= rd_idx_in;
      hit_ff    <= hit_in;
      slot_ff   <= slot_in;
      reject_ff <= reject_in;
      rsp_ff    <= rsp_in;
   end

   assign hit_now = pend_ff && (rd_data_ff == req_ff.value);
   assign last    = count_ff - CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      rd_idx_in    = rd_idx_ff;
      hit_in       = hit_ff;
      slot_in      = slot_ff;
      reject_in    = reject_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      mem_wa       = count_ff[ADDR_W-1:0];
      mem_wd       = req_ff.value;
      mem_ra       = idx_ff[ADDR_W-1:0];
      req_stall    = (state_ff != ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               idx_in    = '0;
               hit_in    = 1'b0;
               reject_in = 1'b0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit_now) begin
               hit_in   = 1'b1;
               slot_in  = rd_idx_ff;
               state_in = ST_UPDATE;
            end else if (idx_ff == count_ff) begin
               if (!pend_ff) begin
                  state_in = ST_UPDATE;
               end
            end else begin
               pend_in   = 1'b1;
               rd_idx_in = idx_ff[ADDR_W-1:0];
               idx_in    = idx_ff + CNT_W'(1);
            end
         end
         ST_UPDATE: begin
            state_in = ST_DONE;
            case (req_ff.kind)
               KIND_INSERT: begin
                  if (!hit_ff) begin
                     if (count_ff < CNT_W'(CAPACITY_MAX)) begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        reject_in = 1'b1;
                     end
                  end
               end
               KIND_REMOVE: begin
                  if (hit_ff) begin
                     count_in = last;
                     mem_ra   = last[ADDR_W-1:0];
                     state_in = ST_MOVE;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_MOVE: begin
            mem_we   = 1'b1;
            mem_wa   = slot_ff;
            mem_wd   = rd_data_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_in.was_present = hit_ff;
               rsp_in.full_reject = reject_ff;
               rsp_in.count       = COUNT_W'(count_ff);
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY_MAX))
      else $error("count above capacity");

   a_count_change: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> ($past(state_ff) == ST_UPDATE))
      else $error("count changed outside update");

   a_no_read_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_ff)
      else $error("table read pending while idle");

   a_reject_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && reject_ff) |-> (count_ff == CNT_W'(CAPACITY_MAX) && !hit_ff))
      else $error("reject without full table");

endmodule

[bench/bounded_value_set_top_test.sv]
// self-checking testbench for the bounded value set: shadow set predictor and random traffic
module bounded_value_set_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bvs_pkg::*;

   localparam int DEPTH = CAPACITY_MAX_DEFAULT;
   localparam int POOL_SIZE = 200;

   typedef enum {MODE_FILL, MODE_MIX, MODE_DRAIN} mode_type;

   class shadow_set;
      logic [VALUE_W-1:0] held [DEPTH];
      int                 held_count;
      rsp_type            due_responses [$];
      int                 errors;

      function new();
         held_count = 0;
         errors = 0;
         foreach (held[i]) held[i] = '0;
      endfunction

      function int slot_of(logic [VALUE_W-1:0] v);
         for (int i = 0; i < held_count; i++) begin
            if (held[i] == v) return i;
         end
         return -1;
      endfunction

      function logic [VALUE_W-1:0] pick_held();
         return held[$urandom_range(0, held_count - 1)];
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch at %0t: %s", $realtime, msg);
      endtask

      function void note_request(req_type r);
         rsp_type e;
         int      slot;
         slot = slot_of(r.value);
         e.was_present = (slot >= 0);
         e.full_reject = 1'b0;
         if (r.kind == KIND_INSERT) begin
            if (slot < 0) begin
               if (held_count < DEPTH) begin
                  held[held_count] = r.value;
                  held_count++;
               end else begin
                  e.full_reject = 1'b1;
               end
            end
         end else if (r.kind == KIND_REMOVE) begin
            if (slot >= 0) begin
               held_count--;
               held[slot] = held[held_count];
            end
         end
         e.count = COUNT_W'(held_count);
         due_responses.push_back(e);
      endfunction

      task check_response(rsp_type got);
         rsp_type e;
         if (due_responses.size() == 0) begin
            report("transaction with nothing expected");
         end else begin
            e = due_responses.pop_front();
            if (got.was_present !== e.was_present)
               report($sformatf("was_present %b, expected %b", got.was_present, e.was_present));
            if (got.full_reject !== e.full_reject)
               report($sformatf("full_reject %b, expected %b", got.full_reject, e.full_reject));
            if (got.count !== e.count)
               report($sformatf("count %0d, expected %0d", got.count, e.count));
         end
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   shadow_set          sb;
   bit                 calm = 1'b0;
   logic [VALUE_W-1:0] pool [POOL_SIZE];

   bounded_value_set_top #(.CAPACITY_MAX(DEPTH)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function int idle_cycles();
      if (calm) return 0;
      return $urandom_range(0, 17);
   endfunction

   task automatic send_request(kind_type k, logic [VALUE_W-1:0] v);
      int      gap;
      req_type r;
      r.kind = k;
      r.value = v;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
   endtask

   task automatic drain_responses();
      int gap;
      forever begin
         gap = idle_cycles();
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         sb.check_response(rsp_data);
      end
   endtask

   function logic [VALUE_W-1:0] pick_value(kind_type k);
      int r;
      r = $urandom_range(0, 99);
      if (k != KIND_INSERT && sb.held_count > 0 && r < 60) return sb.pick_held();
      if (r < 85) return pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom;
   endfunction

   function kind_type pick_kind(mode_type mode);
      int r;
      r = $urandom_range(0, 99);
      case (mode)
         MODE_FILL: begin
            if (r < 75) return KIND_INSERT;
            if (r < 85) return KIND_REMOVE;
         end
         MODE_DRAIN: begin
            if (r < 15) return KIND_INSERT;
            if (r < 80) return KIND_REMOVE;
         end
         default: begin
            if (r < 40) return KIND_INSERT;
            if (r < 70) return KIND_REMOVE;
         end
      endcase
      if (r < 97) return KIND_QUERY;
      return KIND_SPARE;
   endfunction

   initial begin
      mode_type           mode;
      int                 seg_left;
      kind_type           k;
      logic [VALUE_W-1:0] v;
      sb = new();
      foreach (pool[i]) pool[i] = $urandom;
      pool[0] = 32'h8000_0000;
      pool[1] = 32'h7fff_ffff;
      pool[2] = 32'h0000_0000;
      pool[3] = 32'hffff_ffff;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      fork
         drain_responses();
      join_none

      send_request(KIND_QUERY,  32'h0000_0000);
      send_request(KIND_REMOVE, 32'h0000_0000);
      send_request(KIND_INSERT, 32'h8000_0000);
      send_request(KIND_INSERT, 32'h7fff_ffff);
      send_request(KIND_INSERT, 32'h0000_0000);
      send_request(KIND_INSERT, 32'hffff_ffff);
      send_request(KIND_INSERT, 32'h5555_5555);
      send_request(KIND_INSERT, 32'haaaa_aaaa);
      send_request(KIND_INSERT, 32'h7fff_ffff);
      send_request(KIND_QUERY,  32'h8000_0000);
      send_request(KIND_QUERY,  32'h1234_5678);
      send_request(KIND_SPARE,  32'h7fff_ffff);
      send_request(KIND_SPARE,  32'h1234_5678);
      send_request(KIND_REMOVE, 32'h1234_5678);
      send_request(KIND_REMOVE, 32'h8000_0000);
      send_request(KIND_REMOVE, 32'haaaa_aaaa);
      send_request(KIND_QUERY,  32'hffff_ffff);
      send_request(KIND_QUERY,  32'h8000_0000);
      send_request(KIND_REMOVE, 32'h7fff_ffff);
      send_request(KIND_REMOVE, 32'h0000_0000);
      send_request(KIND_REMOVE, 32'hffff_ffff);
      send_request(KIND_REMOVE, 32'h5555_5555);
      send_request(KIND_REMOVE, 32'h5555_5555);
      send_request(KIND_QUERY,  32'h5555_5555);

      mode = MODE_FILL;
      seg_left = $urandom_range(150, 300);
      for (int n = 0; n < 1750; n++) begin
         if (seg_left == 0) begin
            case (mode)
               MODE_FILL:  mode = MODE_MIX;
               MODE_MIX:   mode = ($urandom_range(0, 1) != 0) ? MODE_DRAIN : MODE_FILL;
               default:    mode = MODE_FILL;
            endcase
            seg_left = (mode == MODE_FILL) ? $urandom_range(150, 300) : $urandom_range(60, 200);
            calm = ($urandom_range(0, 3) == 0);
         end
         seg_left--;
         k = pick_kind(mode);
         v = pick_value(k);
         send_request(k, v);
      end
      req_valid <= 1'b0;

      while (sb.due_responses.size() != 0) @(posedge clock);
      repeat (DEPTH + 20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("timeout with %0d transactions outstanding", sb.due_responses.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

[sim.f]
src/bvs_pkg.sv
src/bounded_value_set_top.sv
bench/bounded_value_set_top_test.sv
